[design/lncp_pkg.sv]
// ----------------------------------------------------------------------------
// lncp_pkg
// Shared types, constants and helpers for the line near-clip projection block.
// ----------------------------------------------------------------------------
package lncp_pkg;

  localparam int FRAC_BITS   = 12;
  localparam int SCREEN_BITS = 10;
  localparam int VAL_W       = 16;
  localparam int SIZE_W      = SCREEN_BITS + 1;
  localparam int NEAR_W      = 15;
  localparam int IN_W        = 6 * VAL_W;
  localparam int OUT_W       = ((4 * SCREEN_BITS + 7) / 8) * 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [SIZE_W-1:0] SIZE_MAX     = SIZE_W'(1 << SCREEN_BITS);
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(80);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(40);
  localparam logic [NEAR_W-1:0] NEAR_RESET   = NEAR_W'(((1 << FRAC_BITS) + 5) / 10);

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_NEAR   = 2'd2
  } reg_idx_t;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [NEAR_W-1:0] near_plane;
  } cfg_t;

  // clipped segment handed from front to back
  typedef struct packed {
    logic rej;
    val_t x1;
    val_t y1;
    val_t w1;
    val_t x2;
    val_t y2;
    val_t w2;
  } seg_t;

  // screen size with zero raised to one and oversize saturated
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
    logic [SIZE_W-1:0] s;
    s = r;
    if (r == '0) begin
      s = SIZE_W'(1);
    end else if (r > SIZE_MAX) begin
      s = SIZE_MAX;
    end
    return s;
  endfunction

endpackage

[design/lncp_div.sv]
// ----------------------------------------------------------------------------
// lncp_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// The operands are registered, then pass through one register per quotient bit
// while en is high; the quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
module lncp_div #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 16,
  parameter int Q_W   = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  localparam int W = DEN_W + Q_W;

  logic [NUM_W-1:0] rem [0:Q_W];
  logic [DEN_W-1:0] dv  [0:Q_W];
  logic [Q_W-1:0]   qv  [0:Q_W];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dv[0]  <= den;
      qv[0]  <= '0;
    end
  end

  genvar i;
  generate
    for (i = 0; i < Q_W; i++) begin : g_step
      logic [W-1:0] r_ext;
      logic [W-1:0] trial;
      logic         take;

      assign r_ext = W'(rem[i]);
      assign trial = W'(dv[i]) << (Q_W - 1 - i);
      assign take  = (r_ext >= trial);

      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= take ? NUM_W'(r_ext - trial) : rem[i];
          dv[i+1]  <= dv[i];
          qv[i+1]  <= qv[i] | (take ? (Q_W'(1) << (Q_W - 1 - i)) : '0);
        end
      end
    end
  endgenerate

  assign quo = qv[Q_W];

endmodule

[design/lncp_fifo.sv]
// ----------------------------------------------------------------------------
// lncp_fifo
// Short register queue between the clip front end and the mapping back end.
// ----------------------------------------------------------------------------
module lncp_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lncp_pkg::seg_t  wdata,
  output logic            full,
  input  logic            pop,
  output lncp_pkg::seg_t  rdata,
  output logic            empty
);

  localparam int DEPTH = lncp_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  lncp_pkg::seg_t mem [0:DEPTH-1];
  logic [AW-1:0]  wp;
  logic [AW-1:0]  rp;
  logic [AW:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  assign rdata = mem[rp];
  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + (AW+1)'(1))
    else $error("queue count not incremented on push");

endmodule

[design/lncp_front.sv]
// ----------------------------------------------------------------------------
// lncp_front
// Accepts segments, classifies endpoints against the near plane and replaces
// a hidden endpoint by its interpolated point through pipelined dividers.
// ----------------------------------------------------------------------------
module lncp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [lncp_pkg::IN_W-1:0]  s_tdata,
  input  lncp_pkg::cfg_t             cfg,
  input  logic                       q_full,
  output logic                       q_push,
  output lncp_pkg::seg_t             q_data
);

  localparam int QW   = lncp_pkg::VAL_W;
  localparam int NUMW = lncp_pkg::NEAR_W + lncp_pkg::VAL_W;
  localparam int DLAT = QW + 1;

  typedef struct packed {
    logic           rej;
    logic           clip1;
    logic           clip2;
    logic           negx;
    logic           negy;
    lncp_pkg::val_t x1;
    lncp_pkg::val_t y1;
    lncp_pkg::val_t w1;
    lncp_pkg::val_t x2;
    lncp_pkg::val_t y2;
    lncp_pkg::val_t w2;
  } fside_t;

  logic           en;
  logic           f1_v;
  lncp_pkg::val_t x1, y1, w1, x2, y2, w2;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (en) begin
      f1_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= s_tdata[15:0];
      y1 <= s_tdata[31:16];
      w1 <= s_tdata[47:32];
      x2 <= s_tdata[63:48];
      y2 <= s_tdata[79:64];
      w2 <= s_tdata[95:80];
    end
  end

  // classification and interpolation operands
  logic [lncp_pkg::NEAR_W-1:0] nearw;
  lncp_pkg::val_t              near_s;
  logic                        out1, out2;
  lncp_pkg::val_t              in_x, in_y, in_w, out_x, out_y, out_w;
  logic signed [16:0]          a_full, den_full, dx, dy;
  logic [lncp_pkg::NEAR_W-1:0] a;
  logic [15:0]                 den, absdx, absdy;
  logic [NUMW-1:0]             numx, numy;
  fside_t                      cur;

  always_comb begin
    nearw  = (cfg.near_plane == '0) ? lncp_pkg::NEAR_W'(1) : cfg.near_plane;
    near_s = {1'b0, nearw};
    out1   = (w1 < near_s);
    out2   = (w2 < near_s);
    // the visible endpoint is the interpolation origin
    in_x   = out1 ? x2 : x1;
    in_y   = out1 ? y2 : y1;
    in_w   = out1 ? w2 : w1;
    out_x  = out1 ? x1 : x2;
    out_y  = out1 ? y1 : y2;
    out_w  = out1 ? w1 : w2;
    a_full   = {in_w[15], in_w} - {near_s[15], near_s};
    den_full = {in_w[15], in_w} - {out_w[15], out_w};
    dx       = {out_x[15], out_x} - {in_x[15], in_x};
    dy       = {out_y[15], out_y} - {in_y[15], in_y};
    a        = a_full[lncp_pkg::NEAR_W-1:0];
    den      = den_full[15:0];
    absdx    = dx[16] ? 16'(-dx) : dx[15:0];
    absdy    = dy[16] ? 16'(-dy) : dy[15:0];
    numx     = NUMW'(a) * NUMW'(absdx);
    numy     = NUMW'(a) * NUMW'(absdy);
    cur.rej   = out1 && out2;
    cur.clip1 = out1 && !out2;
    cur.clip2 = out2 && !out1;
    cur.negx  = dx[16];
    cur.negy  = dy[16];
    cur.x1    = x1;
    cur.y1    = y1;
    cur.w1    = w1;
    cur.x2    = x2;
    cur.y2    = y2;
    cur.w2    = w2;
  end

  logic [QW-1:0] qx, qy;

  lncp_div #(.NUM_W(NUMW), .DEN_W(16), .Q_W(QW)) u_div_x (
    .clk (clk), .en (en), .num (numx), .den (den), .quo (qx)
  );

  lncp_div #(.NUM_W(NUMW), .DEN_W(16), .Q_W(QW)) u_div_y (
    .clk (clk), .en (en), .num (numy), .den (den), .quo (qy)
  );

  // side data travels beside the dividers
  logic [DLAT-1:0] fv;
  fside_t          fs [0:DLAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (en) begin
      fv <= {fv[DLAT-2:0], f1_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fs[0] <= cur;
      for (int i = 1; i < DLAT; i++) begin
        fs[i] <= fs[i-1];
      end
    end
  end

  fside_t             last;
  lncp_pkg::val_t     bx, by, xc, yc;
  logic [17:0]        xs, ys;

  always_comb begin
    last = fs[DLAT-1];
    bx   = last.clip1 ? last.x2 : last.x1;
    by   = last.clip1 ? last.y2 : last.y1;
    xs   = {{2{bx[15]}}, bx} + (last.negx ? -{2'b00, qx} : {2'b00, qx});
    ys   = {{2{by[15]}}, by} + (last.negy ? -{2'b00, qy} : {2'b00, qy});
    xc   = xs[15:0];
    yc   = ys[15:0];
    q_data.rej = last.rej;
    q_data.x1  = last.clip1 ? xc : last.x1;
    q_data.y1  = last.clip1 ? yc : last.y1;
    q_data.w1  = last.clip1 ? near_s : last.w1;
    q_data.x2  = last.clip2 ? xc : last.x2;
    q_data.y2  = last.clip2 ? yc : last.y2;
    q_data.w2  = last.clip2 ? near_s : last.w2;
  end

  assign en       = !(fv[DLAT-1] && q_full);
  assign q_push   = fv[DLAT-1] && !q_full;
  assign s_tready = en;

endmodule

[design/lncp_back.sv]
// ----------------------------------------------------------------------------
// lncp_back
// Maps clipped endpoints to clamped screen columns and rows through four
// pipelined dividers and drives the output register.
// ----------------------------------------------------------------------------
module lncp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  lncp_pkg::cfg_t              cfg,
  input  logic                        q_empty,
  input  lncp_pkg::seg_t              q_data,
  output logic                        q_pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [lncp_pkg::OUT_W-1:0]  m_tdata,
  output logic                        m_tuser
);

  localparam int SB   = lncp_pkg::SCREEN_BITS;
  localparam int SW   = lncp_pkg::SIZE_W;
  localparam int NUMW = lncp_pkg::VAL_W + SB;
  localparam int DENW = lncp_pkg::VAL_W;
  localparam int QW   = SW;
  localparam int CW   = DENW + QW;
  localparam int DLAT = QW + 1;

  typedef struct packed {
    logic       rej;
    logic [3:0] neg;
    logic [3:0] ovf;
  } bside_t;

  logic en;
  logic b0_v;
  lncp_pkg::seg_t b0;

  assign en    = !m_tvalid || m_tready;
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_v <= 1'b0;
    end else if (en) begin
      b0_v <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b0 <= q_data;
    end
  end

  logic [SW-1:0] wd, ht;
  logic [SB-1:0] wm1, hm1;

  always_comb begin
    wd  = lncp_pkg::eff_size(cfg.width);
    ht  = lncp_pkg::eff_size(cfg.height);
    wm1 = SB'(wd - SW'(1));
    hm1 = SB'(ht - SW'(1));
  end

  // sign flag and scaled numerator: (p + w) or (w - p), times size minus one
  function automatic logic [NUMW:0] scaled(input lncp_pkg::val_t p,
                                           input lncp_pkg::val_t w,
                                           input logic sub,
                                           input logic [SB-1:0] k);
    logic [16:0] s;
    logic [NUMW-1:0] n;
    s = sub ? ({w[15], w} - {p[15], p}) : ({p[15], p} + {w[15], w});
    n = NUMW'(s[15:0]) * NUMW'(k);
    return {s[16], n};
  endfunction

  logic            b1_v;
  logic            b1_rej;
  logic [NUMW-1:0] num [0:3];
  logic [3:0]      neg;
  logic [DENW-1:0] den1, den2;
  logic [NUMW:0]   sc [0:3];

  always_comb begin
    sc[0] = scaled(b0.x1, b0.w1, 1'b0, wm1);
    sc[1] = scaled(b0.y1, b0.w1, 1'b1, hm1);
    sc[2] = scaled(b0.x2, b0.w2, 1'b0, wm1);
    sc[3] = scaled(b0.y2, b0.w2, 1'b1, hm1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
    end else if (en) begin
      b1_v <= b0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_rej <= b0.rej;
      for (int i = 0; i < 4; i++) begin
        num[i] <= sc[i][NUMW-1:0];
        neg[i] <= sc[i][NUMW];
      end
      den1 <= {b0.w1[DENW-2:0], 1'b0};
      den2 <= {b0.w2[DENW-2:0], 1'b0};
    end
  end

  logic [DENW-1:0] dsel [0:3];
  logic [3:0]      ovf;
  logic [QW-1:0]   quo  [0:3];

  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_map
      assign dsel[g] = (g < 2) ? den1 : den2;
      // quotient too large for the divider means it clamps anyway
      assign ovf[g]  = (CW'(num[g]) >= (CW'(dsel[g]) << QW));

      lncp_div #(.NUM_W(NUMW), .DEN_W(DENW), .Q_W(QW)) u_div (
        .clk (clk), .en (en), .num (num[g]), .den (dsel[g]), .quo (quo[g])
      );
    end
  endgenerate

  logic [DLAT-1:0] bv;
  bside_t          bs [0:DLAT-1];
  bside_t          bcur;

  assign bcur = '{rej: b1_rej, neg: neg, ovf: ovf};

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= '0;
    end else if (en) begin
      bv <= {bv[DLAT-2:0], b1_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bs[0] <= bcur;
      for (int i = 1; i < DLAT; i++) begin
        bs[i] <= bs[i-1];
      end
    end
  end

  bside_t        last;
  logic [SB-1:0] crd [0:3];
  logic [SW-1:0] sz;

  always_comb begin
    last = bs[DLAT-1];
    for (int i = 0; i < 4; i++) begin
      sz = ((i % 2) == 0) ? wd : ht;
      if (last.rej || last.neg[i]) begin
        crd[i] = '0;
      end else if (last.ovf[i] || (quo[i] >= sz)) begin
        crd[i] = SB'(sz - SW'(1));
      end else begin
        crd[i] = quo[i][SB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= bv[DLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= lncp_pkg::OUT_W'({crd[3], crd[2], crd[1], crd[0]});
      m_tuser <= last.rej;
    end
  end

endmodule

[design/line_near_clip_project.sv]
// ----------------------------------------------------------------------------
// line_near_clip_project
// Near-plane line clip, perspective divide and screen mapping of segments.
// ----------------------------------------------------------------------------
// One segment enters per transfer on the s_ group: six signed Q4.12 values,
// first_x in the lowest bits up to second_w. Each segment gives one result on
// the m_ group: four screen coordinates in m_tdata and the rejected flag in
// m_tuser; a rejected segment carries all-zero coordinates.
// Screen width, height and the near plane are written through cfg_we, cfg_addr
// and cfg_data; the user must do so only while no segment is in flight, the
// block does not enforce this. Throughput is one segment per clock while the
// receiver does not stall. From the input transfer to the output register a
// segment passes one input register, the 17-stage clip divider, the queue, two
// mapping stages and the 12-stage mapping dividers, one quotient bit per stage.
// When the receiver stalls, the mapping pipeline holds, the four-entry queue
// fills, and only then does s_tready drop. Synchronous reset empties both
// pipelines and the queue and loads width 80, height 40 and near plane 410.
// ----------------------------------------------------------------------------
module line_near_clip_project (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // first_x, first_y, first_w, second_x, second_y, second_w
  input  logic [lncp_pkg::IN_W-1:0]      s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // first_col, first_row, second_col, second_row
  output logic [lncp_pkg::OUT_W-1:0]     m_tdata,
  // rejected
  output logic                           m_tuser,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_addr,
  input  logic [lncp_pkg::NEAR_W-1:0]    cfg_data
);

  logic [lncp_pkg::SIZE_W-1:0] screen_width;
  logic [lncp_pkg::SIZE_W-1:0] screen_height;
  logic [lncp_pkg::NEAR_W-1:0] near_plane;
  lncp_pkg::cfg_t              cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= lncp_pkg::WIDTH_RESET;
      screen_height <= lncp_pkg::HEIGHT_RESET;
      near_plane    <= lncp_pkg::NEAR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        lncp_pkg::REG_WIDTH:  screen_width  <= cfg_data[lncp_pkg::SIZE_W-1:0];
        lncp_pkg::REG_HEIGHT: screen_height <= cfg_data[lncp_pkg::SIZE_W-1:0];
        lncp_pkg::REG_NEAR:   near_plane    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.width      = screen_width;
  assign cfg.height     = screen_height;
  assign cfg.near_plane = near_plane;

  logic           q_full, q_push, q_pop, q_empty;
  lncp_pkg::seg_t q_wdata, q_rdata;

  lncp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  lncp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  lncp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("rejected segment with nonzero coordinates");

endmodule
